// ===== rtl/core/fasta_fastq_record_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the FASTA/FASTQ record parser
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FASTA_FASTQ_RECORD_PARSER_TOP_MACROS_SVH
`define FASTA_FASTQ_RECORD_PARSER_TOP_MACROS_SVH

// Same-cycle implication.
`define FQP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FQP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fqp_pkg.sv =====
// ----------------------------------------------------------------------------
// fqp_pkg
// Types, codes and helpers shared by the FASTA/FASTQ record parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fqp_pkg;

  localparam int unsigned FQP_LEN_BITS   = 32;  // internal counter width
  localparam int unsigned FQP_OUT_W      = 32;  // length field width on ports
  localparam int unsigned FQP_FIFO_DEPTH = 4;   // result queue entries
  localparam logic [7:0]  FQP_QOFS_RESET = 8'd33;

  localparam logic [7:0] CH_AT    = 8'h40;  // '@'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    EV_START   = 3'd0,
    EV_NAME    = 3'd1,
    EV_HDR_END = 3'd2,
    EV_BASE    = 3'd3,
    EV_QUAL    = 3'd4,
    EV_REC_END = 3'd5,
    EV_ERROR   = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    ERR_BAD_START = 3'd0,
    ERR_EOF_NAME  = 3'd1,
    ERR_NO_NAME   = 3'd2,
    ERR_EOF_FASTQ = 3'd3,
    ERR_NO_PLUS   = 3'd4,
    ERR_LEN_MISM  = 3'd5
  } err_e;

  typedef enum logic [7:0] {
    MODE_IDLE     = 8'b0000_0001,
    MODE_NAME     = 8'b0000_0010,
    MODE_FQ_SEQ   = 8'b0000_0100,
    MODE_FQ_PLUS  = 8'b0000_1000,
    MODE_FQ_PLINE = 8'b0001_0000,
    MODE_FQ_QUAL  = 8'b0010_0000,
    MODE_FA_SEQ   = 8'b0100_0000,
    MODE_ERROR    = 8'b1000_0000
  } mode_e;

  typedef struct packed {
    logic [2:0]           event_res;
    logic [7:0]           data_byte_out;
    logic                 is_fastq;
    logic [FQP_OUT_W-1:0] short_name_length;
    logic [FQP_OUT_W-1:0] name_length;
    logic [FQP_OUT_W-1:0] sequence_length;
    logic [8:0]           quality_score;
    logic [2:0]           error_code;
    logic                 last;
  } res_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
  endfunction

  // Build a result item; last is set by the caller.
  function automatic res_t make_res(input event_e ev, input logic [7:0] b,
                                    input logic fq,
                                    input logic [FQP_OUT_W-1:0] sn,
                                    input logic [FQP_OUT_W-1:0] nl,
                                    input logic [FQP_OUT_W-1:0] sl,
                                    input logic [8:0] qs, input err_e err);
    res_t r;
    r.event_res         = ev;
    r.data_byte_out     = b;
    r.is_fastq          = fq;
    r.short_name_length = sn;
    r.name_length       = nl;
    r.sequence_length   = sl;
    r.quality_score     = qs;
    r.error_code        = err;
    r.last              = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fasta_fastq_record_parser_top.sv =====
// ----------------------------------------------------------------------------
// fasta_fastq_record_parser_top
// Parses FASTA/FASTQ text one byte per item into name, base, quality, record
// and error events with header and sequence lengths.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid_i/in_ready_o | data_byte_i, end_of_stream_i
//  out     | output    | out_valid_o/out_ready_i | event_res_o .. last_o
//  cfg     | input     | quality_offset_we_i   | quality_offset_i
//
//  One input item per cycle while in_ready_o is high; parse state updates in the
//  cycle of acceptance. Results are written into a 4-entry queue on acceptance
//  and leave it one per cycle while out_ready_i is high. An item yields at most
//  two results (FASTA record end followed by a new record start).
//  in_ready_o drops while fewer than two queue entries are free.
//  Reset clears parse state and queue; quality_offset returns to 33.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fasta_fastq_record_parser_top
  import fqp_pkg::*;
#(
  parameter int unsigned LEN_BITS   = FQP_LEN_BITS,
  parameter int unsigned FIFO_DEPTH = FQP_FIFO_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              quality_offset_we_i,
  input  wire logic [7:0]        quality_offset_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              end_of_stream_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             event_res_o,
  output logic [7:0]             data_byte_out_o,
  output logic                   is_fastq_o,
  output logic [FQP_OUT_W-1:0]   short_name_length_o,
  output logic [FQP_OUT_W-1:0]   name_length_o,
  output logic [FQP_OUT_W-1:0]   sequence_length_o,
  output logic signed [8:0]      quality_score_o,
  output logic [2:0]             error_code_o,
  output logic                   last_o
);

  typedef logic [LEN_BITS-1:0] len_t;

  function automatic len_t sat_inc(input len_t v);
    return (v == '1) ? v : len_t'(v + 1'b1);
  endfunction

  function automatic logic [FQP_OUT_W-1:0] to_out(input len_t v);
    return FQP_OUT_W'(v);
  endfunction

  logic [7:0] qofs_q;
  mode_e      mode_q, mode_d;
  logic       fastq_q, fastq_d;
  logic       begun_q, begun_d;
  logic       frozen_q, frozen_d;
  logic       line_start_q, line_start_d;
  len_t       name_cnt_q, name_cnt_d;
  len_t       short_cnt_q, short_cnt_d;
  len_t       trim_cnt_q, trim_cnt_d;
  len_t       base_cnt_q, base_cnt_d;
  len_t       qual_cnt_q, qual_cnt_d;

  logic       in_fire;
  logic [7:0] b;
  logic [1:0] n_res;
  res_t       res0, res1, head;
  logic [8:0] qs;
  logic       room2;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = room2;
  assign b          = data_byte_i;
  assign qs         = {1'b0, b} - {1'b0, qofs_q};

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qofs_q <= FQP_QOFS_RESET;
    end else if (quality_offset_we_i) begin
      qofs_q <= quality_offset_i;
    end
  end

  // parse one accepted item: next state and up to two results
  always_comb begin
    mode_d       = mode_q;
    fastq_d      = fastq_q;
    begun_d      = begun_q;
    frozen_d     = frozen_q;
    line_start_d = line_start_q;
    name_cnt_d   = name_cnt_q;
    short_cnt_d  = short_cnt_q;
    trim_cnt_d   = trim_cnt_q;
    base_cnt_d   = base_cnt_q;
    qual_cnt_d   = qual_cnt_q;
    n_res        = 2'd0;
    res0         = '0;
    res1         = '0;

    if (in_fire) begin
      if (end_of_stream_i) begin
        case (mode_q)
          MODE_NAME: begin
            res0  = make_res(EV_ERROR, '0, fastq_q, '0, '0, '0, '0, ERR_EOF_NAME);
            n_res = 2'd1;
          end
          MODE_FQ_SEQ, MODE_FQ_PLUS, MODE_FQ_PLINE, MODE_FQ_QUAL: begin
            res0  = make_res(EV_ERROR, '0, fastq_q, '0, '0, '0, '0, ERR_EOF_FASTQ);
            n_res = 2'd1;
          end
          MODE_FA_SEQ: begin
            res0  = make_res(EV_REC_END, '0, fastq_q, '0, '0, to_out(base_cnt_q),
                             '0, ERR_BAD_START);
            n_res = 2'd1;
          end
          default: begin
          end
        endcase
        // return all parse state to reset
        mode_d       = MODE_IDLE;
        fastq_d      = 1'b0;
        begun_d      = 1'b0;
        frozen_d     = 1'b0;
        line_start_d = 1'b1;
        name_cnt_d   = '0;
        short_cnt_d  = '0;
        trim_cnt_d   = '0;
        base_cnt_d   = '0;
        qual_cnt_d   = '0;
      end else begin
        case (mode_q)
          MODE_IDLE: begin
            if (b == CH_AT || b == CH_GT) begin
              res0         = make_res(EV_START, '0, b == CH_AT, '0, '0, '0, '0,
                                      ERR_BAD_START);
              mode_d       = MODE_NAME;
              fastq_d      = (b == CH_AT);
              begun_d      = 1'b0;
              frozen_d     = 1'b0;
              line_start_d = 1'b1;
              name_cnt_d   = '0;
              short_cnt_d  = '0;
              trim_cnt_d   = '0;
              base_cnt_d   = '0;
              qual_cnt_d   = '0;
            end else begin
              res0   = make_res(EV_ERROR, '0, fastq_q, '0, '0, '0, '0, ERR_BAD_START);
              mode_d = MODE_ERROR;
            end
            n_res = 2'd1;
          end
          MODE_NAME: begin
            if (b == CH_NL) begin
              if (!begun_q) begin
                res0   = make_res(EV_ERROR, '0, fastq_q, '0, '0, '0, '0, ERR_NO_NAME);
                mode_d = MODE_ERROR;
              end else begin
                res0 = make_res(EV_HDR_END, '0, fastq_q, to_out(short_cnt_q),
                                to_out(trim_cnt_q), '0, '0, ERR_BAD_START);
                mode_d       = fastq_q ? MODE_FQ_SEQ : MODE_FA_SEQ;
                line_start_d = 1'b1;
              end
              n_res = 2'd1;
            end else if (begun_q || !is_blank(b)) begin
              // count name byte; blanks freeze the short name
              begun_d    = 1'b1;
              name_cnt_d = sat_inc(name_cnt_q);
              if (is_blank(b)) begin
                frozen_d = 1'b1;
              end else begin
                trim_cnt_d = sat_inc(name_cnt_q);
                if (!frozen_q) begin
                  short_cnt_d = sat_inc(short_cnt_q);
                end
              end
              res0  = make_res(EV_NAME, b, fastq_q, '0, '0, '0, '0, ERR_BAD_START);
              n_res = 2'd1;
            end
          end
          MODE_FQ_SEQ: begin
            if (b == CH_NL) begin
              mode_d = MODE_FQ_PLUS;
            end else if (!is_blank(b)) begin
              base_cnt_d = sat_inc(base_cnt_q);
              res0  = make_res(EV_BASE, b, 1'b1, '0, '0, '0, '0, ERR_BAD_START);
              n_res = 2'd1;
            end
          end
          MODE_FQ_PLUS: begin
            if (b == CH_PLUS) begin
              mode_d = MODE_FQ_PLINE;
            end else begin
              res0   = make_res(EV_ERROR, '0, fastq_q, '0, '0, '0, '0, ERR_NO_PLUS);
              mode_d = MODE_ERROR;
              n_res  = 2'd1;
            end
          end
          MODE_FQ_PLINE: begin
            if (b == CH_NL) begin
              mode_d = MODE_FQ_QUAL;
            end
          end
          MODE_FQ_QUAL: begin
            if (b == CH_NL) begin
              if (qual_cnt_q != base_cnt_q) begin
                res0   = make_res(EV_ERROR, '0, fastq_q, '0, '0, '0, '0, ERR_LEN_MISM);
                mode_d = MODE_ERROR;
              end else begin
                res0 = make_res(EV_REC_END, '0, 1'b1, '0, '0, to_out(base_cnt_q),
                                '0, ERR_BAD_START);
                mode_d       = MODE_IDLE;
                line_start_d = 1'b1;
              end
              n_res = 2'd1;
            end else if (!is_blank(b)) begin
              qual_cnt_d = sat_inc(qual_cnt_q);
              res0  = make_res(EV_QUAL, '0, 1'b1, '0, '0, '0, qs, ERR_BAD_START);
              n_res = 2'd1;
            end
          end
          MODE_FA_SEQ: begin
            if (line_start_q && (b == CH_AT || b == CH_GT)) begin
              // close this record and open the next one
              res0 = make_res(EV_REC_END, '0, fastq_q, '0, '0, to_out(base_cnt_q),
                              '0, ERR_BAD_START);
              res1 = make_res(EV_START, '0, b == CH_AT, '0, '0, '0, '0,
                              ERR_BAD_START);
              n_res        = 2'd2;
              mode_d       = MODE_NAME;
              fastq_d      = (b == CH_AT);
              begun_d      = 1'b0;
              frozen_d     = 1'b0;
              line_start_d = 1'b1;
              name_cnt_d   = '0;
              short_cnt_d  = '0;
              trim_cnt_d   = '0;
              base_cnt_d   = '0;
              qual_cnt_d   = '0;
            end else if (b == CH_NL) begin
              line_start_d = 1'b1;
            end else begin
              line_start_d = 1'b0;
              if (!is_blank(b)) begin
                base_cnt_d = sat_inc(base_cnt_q);
                res0  = make_res(EV_BASE, b, fastq_q, '0, '0, '0, '0, ERR_BAD_START);
                n_res = 2'd1;
              end
            end
          end
          default: begin
            // sticky error: drop bytes until end of stream
          end
        endcase
      end
    end

    // mark the final result of this item
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      fastq_q      <= 1'b0;
      begun_q      <= 1'b0;
      frozen_q     <= 1'b0;
      line_start_q <= 1'b1;
      name_cnt_q   <= '0;
      short_cnt_q  <= '0;
      trim_cnt_q   <= '0;
      base_cnt_q   <= '0;
      qual_cnt_q   <= '0;
    end else begin
      mode_q       <= mode_d;
      fastq_q      <= fastq_d;
      begun_q      <= begun_d;
      frozen_q     <= frozen_d;
      line_start_q <= line_start_d;
      name_cnt_q   <= name_cnt_d;
      short_cnt_q  <= short_cnt_d;
      trim_cnt_q   <= trim_cnt_d;
      base_cnt_q   <= base_cnt_d;
      qual_cnt_q   <= qual_cnt_d;
    end
  end

  // result queue
  fqp_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (n_res),
    .push0_i     (res0),
    .push1_i     (res1),
    .room2_o     (room2),
    .pop_valid_o (out_valid_o),
    .pop_ready_i (out_ready_i),
    .pop_data_o  (head)
  );

  assign event_res_o         = head.event_res;
  assign data_byte_out_o     = head.data_byte_out;
  assign is_fastq_o          = head.is_fastq;
  assign short_name_length_o = head.short_name_length;
  assign name_length_o       = head.name_length;
  assign sequence_length_o   = head.sequence_length;
  assign quality_score_o     = head.quality_score;
  assign error_code_o        = head.error_code;
  assign last_o              = head.last;

endmodule

`default_nettype wire

// ===== rtl/core/fqp_res_fifo.sv =====
// ----------------------------------------------------------------------------
// fqp_res_fifo
// Result queue: takes up to two items per cycle, gives one per cycle while pop_ready_i is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fqp_res_fifo
  import fqp_pkg::*;
#(
  parameter int unsigned DEPTH = FQP_FIFO_DEPTH  // power of two, at least 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  wire res_t       push0_i,
  input  wire res_t       push1_i,
  output logic            room2_o,
  output logic            pop_valid_o,
  input  wire logic       pop_ready_i,
  output res_t            pop_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  res_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rptr_q];
  // accept a new item only if two free entries are guaranteed
  assign room2_o     = (count_q <= CNT_W'(DEPTH - 2));

  // advance pointers and occupancy
  always_comb begin
    wptr_d  = wptr_q + PTR_W'(push_cnt_i);
    rptr_d  = rptr_q + PTR_W'(pop);
    count_d = count_q + CNT_W'(push_cnt_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // write storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[PTR_W'(wptr_q + 1'b1)] <= push1_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fqp_checker.sv =====
// ----------------------------------------------------------------------------
// fqp_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fasta_fastq_record_parser_top_macros.svh"

module fqp_checker
  import fqp_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [2:0]           event_res_o,
  input wire logic [7:0]           data_byte_out_o,
  input wire logic                 is_fastq_o,
  input wire logic signed [8:0]    quality_score_o,
  input wire logic [2:0]           error_code_o,
  input wire logic                 last_o
);

  // a stalled item holds
  `FQP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(event_res_o) && $stable(last_o),
                   "result item changed while stalled")

  // quality only inside FASTQ records
  `FQP_ASSERT(a_qual_fastq, out_valid_o && event_res_o == EV_QUAL, is_fastq_o,
              "quality item outside a FASTQ record")

  // error code only on error items
  `FQP_ASSERT(a_err_code, out_valid_o && event_res_o != EV_ERROR, error_code_o == '0,
              "error code on a non-error item")

  // a record start is always the final result of its input byte
  `FQP_ASSERT(a_start_last, out_valid_o && event_res_o == EV_START, last_o,
              "record start not marked last")

  // a record end carries no byte and no quality
  `FQP_ASSERT(a_end_byte, out_valid_o && event_res_o == EV_REC_END,
              data_byte_out_o == '0 && quality_score_o == '0,
              "record end carries byte or quality")

endmodule

bind fasta_fastq_record_parser_top fqp_checker u_fqp_checker (.*);

`default_nettype wire

// ===== tb/fasta_fastq_record_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// FASTA/FASTQ record parser testbench
// Feeds text bytes through the valid/ready input, runs its own parser model
// on every accepted byte and compares each result item field by field, in
// order. A short directed table opens the run; random files of well-formed
// and broken records follow under several quality offsets, with random gaps
// on both sides, a long receiver stall and idle drains between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fasta_fastq_record_parser_top_tb
  import fqp_pkg::*;
();

  localparam int STALL_LIMIT  = 2000;  // cycles with no item moving
  localparam int HOLD_CYCLES  = 300;   // long receiver stall
  localparam int PHASE_ITEMS  = 80;    // bytes sent per random phase, at least
  localparam int NUM_PHASES   = 4;
  localparam int DIR_ROWS     = 29;

  localparam logic [1:0] ROW_PRED = 2'd0;  // results come from the parser model
  localparam logic [1:0] ROW_NONE = 2'd1;  // no result
  localparam logic [1:0] ROW_ONE  = 2'd2;  // one typed result
  localparam logic [2:0] NO_CODE  = 3'd0;

  typedef enum logic [2:0] {
    PS_IDLE, PS_NAME, PS_FQ_SEQ, PS_FQ_PLUS, PS_FQ_PLINE, PS_FQ_QUAL, PS_FA_SEQ, PS_ERROR
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] text;
    logic       eos;
    logic [1:0] kind;
    logic [2:0] ev;
    logic [2:0] code;
    logic       fq;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 quality_offset_we_i;
  logic [7:0]           quality_offset_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i;
  logic                 end_of_stream_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [2:0]           event_res_o;
  logic [7:0]           data_byte_out_o;
  logic                 is_fastq_o;
  logic [FQP_OUT_W-1:0] short_name_length_o;
  logic [FQP_OUT_W-1:0] name_length_o;
  logic [FQP_OUT_W-1:0] sequence_length_o;
  logic signed [8:0]    quality_score_o;
  logic [2:0]           error_code_o;
  logic                 last_o;

  fasta_fastq_record_parser_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .quality_offset_we_i (quality_offset_we_i),
    .quality_offset_i    (quality_offset_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .end_of_stream_i     (end_of_stream_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .event_res_o         (event_res_o),
    .data_byte_out_o     (data_byte_out_o),
    .is_fastq_o          (is_fastq_o),
    .short_name_length_o (short_name_length_o),
    .name_length_o       (name_length_o),
    .sequence_length_o   (sequence_length_o),
    .quality_score_o     (quality_score_o),
    .error_code_o        (error_code_o),
    .last_o              (last_o)
  );

  // Parser model state
  parse_mode_e ps_mode;
  logic        ps_fastq;
  logic        ps_name_begun;
  logic [31:0] ps_name_len;
  logic [31:0] ps_short_len;
  logic        ps_short_done;
  logic [31:0] ps_trim_len;
  logic [31:0] ps_bases;
  logic [31:0] ps_quals;
  logic        ps_line_start;
  logic [7:0]  cfg_offset;

  res_t        step_events [0:1];
  int          step_count;
  res_t        parse_events_q [$];
  logic [8:0]  text_q [$];  // {end of stream, byte}

  int          fault_count;
  int          bytes_sent;
  int          live_bytes;
  int          events_seen;
  int          records_closed;
  int          errors_seen;
  int          idle_cycles;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;
  int          rx_wait;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  task automatic clear_parse_state();
    ps_mode       = PS_IDLE;
    ps_fastq      = 1'b0;
    ps_name_begun = 1'b0;
    ps_name_len   = '0;
    ps_short_len  = '0;
    ps_short_done = 1'b0;
    ps_trim_len   = '0;
    ps_bases      = '0;
    ps_quals      = '0;
    ps_line_start = 1'b1;
  endtask

  task automatic emit_event(input event_e ev, input logic [7:0] text, input logic fq,
                            input logic [31:0] sn, input logic [31:0] nl,
                            input logic [31:0] sl, input logic [8:0] qs,
                            input logic [2:0] code);
    res_t r;
    r = '0;
    r.event_res         = ev;
    r.data_byte_out     = text;
    r.is_fastq          = fq;
    r.short_name_length = sn;
    r.name_length       = nl;
    r.sequence_length   = sl;
    r.quality_score     = qs;
    r.error_code        = code;
    step_events[step_count] = r;
    step_count++;
  endtask

  task automatic raise_error(input logic [2:0] code);
    emit_event(EV_ERROR, 8'h00, ps_fastq, '0, '0, '0, '0, code);
    ps_mode = PS_ERROR;
  endtask

  task automatic open_record(input logic fq);
    clear_parse_state();
    ps_fastq = fq;
    ps_mode  = PS_NAME;
    emit_event(EV_START, 8'h00, fq, '0, '0, '0, '0, NO_CODE);
  endtask

  // Advance the model by one accepted byte; results land in step_events
  task automatic parse_byte(input logic [7:0] b, input logic eos);
    logic blank;
    blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
    step_count = 0;
    if (eos) begin
      case (ps_mode)
        PS_NAME: raise_error(ERR_EOF_NAME);
        PS_FQ_SEQ, PS_FQ_PLUS, PS_FQ_PLINE, PS_FQ_QUAL: raise_error(ERR_EOF_FASTQ);
        PS_FA_SEQ: emit_event(EV_REC_END, 8'h00, ps_fastq, '0, '0, ps_bases, '0, NO_CODE);
        default: ;
      endcase
      clear_parse_state();
    end else begin
      case (ps_mode)
        PS_IDLE: begin
          if (b == CH_AT || b == CH_GT) open_record(b == CH_AT);
          else raise_error(ERR_BAD_START);
        end
        PS_NAME: begin
          if (b == CH_NL) begin
            if (!ps_name_begun) begin
              raise_error(ERR_NO_NAME);
            end else begin
              emit_event(EV_HDR_END, 8'h00, ps_fastq, ps_short_len, ps_trim_len, '0, '0,
                         NO_CODE);
              ps_mode       = ps_fastq ? PS_FQ_SEQ : PS_FA_SEQ;
              ps_line_start = 1'b1;
            end
          end else if (ps_name_begun || !blank) begin
            ps_name_begun = 1'b1;
            ps_name_len   = sat_inc(ps_name_len);
            if (blank) begin
              ps_short_done = 1'b1;
            end else begin
              ps_trim_len = ps_name_len;
              if (!ps_short_done) ps_short_len = sat_inc(ps_short_len);
            end
            emit_event(EV_NAME, b, ps_fastq, '0, '0, '0, '0, NO_CODE);
          end
        end
        PS_FQ_SEQ: begin
          if (b == CH_NL) begin
            ps_mode = PS_FQ_PLUS;
          end else if (!blank) begin
            ps_bases = sat_inc(ps_bases);
            emit_event(EV_BASE, b, 1'b1, '0, '0, '0, '0, NO_CODE);
          end
        end
        PS_FQ_PLUS: begin
          if (b == CH_PLUS) ps_mode = PS_FQ_PLINE;
          else raise_error(ERR_NO_PLUS);
        end
        PS_FQ_PLINE: begin
          if (b == CH_NL) ps_mode = PS_FQ_QUAL;
        end
        PS_FQ_QUAL: begin
          if (b == CH_NL) begin
            if (ps_quals != ps_bases) begin
              raise_error(ERR_LEN_MISM);
            end else begin
              emit_event(EV_REC_END, 8'h00, 1'b1, '0, '0, ps_bases, '0, NO_CODE);
              ps_mode       = PS_IDLE;
              ps_line_start = 1'b1;
            end
          end else if (!blank) begin
            ps_quals = sat_inc(ps_quals);
            emit_event(EV_QUAL, 8'h00, 1'b1, '0, '0, '0,
                       {1'b0, b} - {1'b0, cfg_offset}, NO_CODE);
          end
        end
        PS_FA_SEQ: begin
          if (ps_line_start && (b == CH_AT || b == CH_GT)) begin
            emit_event(EV_REC_END, 8'h00, ps_fastq, '0, '0, ps_bases, '0, NO_CODE);
            open_record(b == CH_AT);
          end else if (b == CH_NL) begin
            ps_line_start = 1'b1;
          end else begin
            ps_line_start = 1'b0;
            if (!blank) begin
              ps_bases = sat_inc(ps_bases);
              emit_event(EV_BASE, b, ps_fastq, '0, '0, '0, '0, NO_CODE);
            end
          end
        end
        default: ;
      endcase
    end
    if (step_count > 0) step_events[step_count-1].last = 1'b1;
  endtask

  // Append one expected result item
  task automatic queue_result(input res_t r);
    parse_events_q = {parse_events_q, r};
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one byte, hold it until accepted, then queue its expected events.
  // Entered and left at a falling edge.
  task automatic send_item(input logic [7:0] b, input logic eos, input logic [1:0] kind,
                           input res_t typed);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if (ps_mode != PS_ERROR) live_bytes++;
    parse_byte(b, eos);
    if (kind == ROW_PRED) begin
      for (int i = 0; i < step_count; i++) queue_result(step_events[i]);
    end else if (kind == ROW_ONE) begin
      queue_result(typed);
    end
    @(negedge clk_i);
  endtask

  // Drain, let the block settle, then write the offset
  task automatic write_quality_offset(input logic [7:0] v);
    in_valid_i <= 1'b0;
    while (parse_events_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    quality_offset_we_i <= 1'b1;
    quality_offset_i    <= v;
    @(negedge clk_i);
    quality_offset_we_i <= 1'b0;
    cfg_offset = v;
  endtask

  // ---------------------------------------------------------------------------
  // Random text
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] any_sym();
    logic [7:0] s;
    do s = 8'($urandom_range(0, 255));
    while (s == CH_NL || s == CH_SPACE || s == CH_TAB || s == CH_CR);
    return s;
  endfunction

  function automatic logic [7:0] blank_sym();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  // Append one {end of stream, byte} entry to the text
  task automatic put_entry(input logic [8:0] e);
    text_q = {text_q, e};
  endtask

  task automatic put_text(input logic [7:0] b);
    put_entry({1'b0, b});
  endtask

  task automatic put_name();
    int len;
    len = $urandom_range(1, 8);
    if ($urandom_range(0, 4) == 0) put_text(blank_sym());
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 6) == 0) put_text(blank_sym());
      put_text(($urandom_range(0, 9) == 0) ? any_sym() : 8'($urandom_range(33, 126)));
    end
    if ($urandom_range(0, 4) == 0) put_text(blank_sym());
  endtask

  task automatic put_bases(input int n);
    logic [7:0] nuc;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) put_text(blank_sym());
      case ($urandom_range(0, 4))
        0:       nuc = "A";
        1:       nuc = "C";
        2:       nuc = "G";
        3:       nuc = "T";
        default: nuc = "N";
      endcase
      put_text(($urandom_range(0, 9) == 0) ? any_sym() : nuc);
    end
  endtask

  task automatic put_quals(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) put_text(blank_sym());
      put_text(($urandom_range(0, 6) == 0) ? any_sym() : 8'($urandom_range(33, 126)));
    end
  endtask

  // Header and sequence line of a FASTQ record
  task automatic put_fastq_head(input int n);
    put_text(CH_AT);
    put_name();
    put_text(CH_NL);
    put_bases(n);
    put_text(CH_NL);
  endtask

  task automatic put_plus_line();
    put_text(CH_PLUS);
    repeat ($urandom_range(0, 3)) put_text(any_sym());
    put_text(CH_NL);
  endtask

  // One file: a few records, possibly a broken one, then end of stream
  task automatic build_file();
    int         recs;
    int         n;
    int         pick;
    logic [7:0] s;
    recs = $urandom_range(1, 4);
    for (int r = 0; r < recs; r++) begin
      n = $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0) n = 0;
      else if ($urandom_range(0, 19) == 0) n = $urandom_range(30, 60);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        put_fastq_head(n);
        put_plus_line();
        put_quals(n);
        put_text(CH_NL);
      end else if (pick < 85) begin
        put_text(CH_GT);
        put_name();
        put_text(CH_NL);
        repeat ($urandom_range(1, 3)) begin
          put_bases($urandom_range(0, 15));
          put_text(CH_NL);
        end
      end else begin
        case ($urandom_range(0, 5))
          0: begin  // bad record start
            do s = 8'($urandom_range(0, 255)); while (s == CH_AT || s == CH_GT);
            put_text(s);
          end
          1: begin  // header of blanks only
            put_text(($urandom_range(0, 1) == 1) ? CH_AT : CH_GT);
            repeat ($urandom_range(0, 2)) put_text(blank_sym());
            put_text(CH_NL);
          end
          2: begin  // file ends inside the header
            put_text(($urandom_range(0, 1) == 1) ? CH_AT : CH_GT);
            put_name();
          end
          3: begin  // file ends inside a FASTQ record
            put_fastq_head(n);
            if ($urandom_range(0, 1) == 1) begin
              put_plus_line();
              put_quals(n / 2);
            end
          end
          4: begin  // no plus line
            put_fastq_head(n);
            do s = any_sym(); while (s == CH_PLUS);
            put_text(s);
          end
          default: begin  // quality count off by one
            put_fastq_head(n);
            put_plus_line();
            put_quals((n > 0 && $urandom_range(0, 1) == 1) ? n - 1 : n + 1);
            put_text(CH_NL);
          end
        endcase
        // Noise after the broken record, up to end of stream
        if (ps_mode != PS_NAME) repeat ($urandom_range(0, 3)) put_text(any_sym());
        break;
      end
    end
    put_entry({1'b1, 8'($urandom_range(0, 255))});
    if ($urandom_range(0, 9) == 0) put_entry({1'b1, 8'($urandom_range(0, 255))});
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    rx_wait     = 0;
    forever begin : rx_drive
      int hold_left;
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      fault_count++;
    end
  endtask

  // Compare each accepted result with the oldest expected event
  always @(posedge clk_i) begin : rx_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      events_seen++;
      if (event_res_o == EV_REC_END) records_closed++;
      if (event_res_o == EV_ERROR) errors_seen++;
      if (parse_events_q.size() == 0) begin
        $error("unexpected result item: event %0d", event_res_o);
        fault_count++;
      end else begin
        want = parse_events_q.pop_front();
        check_field("event_res", 32'(want.event_res), 32'(event_res_o));
        check_field("data_byte_out", 32'(want.data_byte_out), 32'(data_byte_out_o));
        check_field("is_fastq", 32'(want.is_fastq), 32'(is_fastq_o));
        check_field("short_name_length", want.short_name_length, short_name_length_o);
        check_field("name_length", want.name_length, name_length_o);
        check_field("sequence_length", want.sequence_length, sequence_length_o);
        check_field("quality_score", 32'(want.quality_score),
                    32'($unsigned(quality_score_o)));
        check_field("error_code", 32'(want.error_code), 32'(error_code_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
      rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    stim_row_t  stim_rows [DIR_ROWS];
    res_t       typed;
    logic [8:0] t;
    logic [7:0] v;
    int         phase_start;

    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    data_byte_i         = 8'h00;
    end_of_stream_i     = 1'b0;
    quality_offset_we_i = 1'b0;
    quality_offset_i    = 8'h00;
    fault_count         = 0;
    bytes_sent          = 0;
    live_bytes          = 0;
    events_seen         = 0;
    records_closed      = 0;
    errors_seen         = 0;
    idle_cycles         = 0;
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    hold_req            = 1'b0;
    cfg_offset          = FQP_QOFS_RESET;
    clear_parse_state();

    // Directed bytes: typed results where obvious, model for the rest
    stim_rows = '{
      '{"A",      1'b0, ROW_ONE,  EV_ERROR, ERR_BAD_START, 1'b0},
      '{8'hFF,    1'b0, ROW_NONE, EV_START, NO_CODE,       1'b0},  // dropped after error
      '{8'h00,    1'b1, ROW_NONE, EV_START, NO_CODE,       1'b0},
      '{CH_GT,    1'b0, ROW_ONE,  EV_START, NO_CODE,       1'b0},
      '{CH_SPACE, 1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_NL,    1'b0, ROW_ONE,  EV_ERROR, ERR_NO_NAME,   1'b0},
      '{8'hFF,    1'b1, ROW_NONE, EV_START, NO_CODE,       1'b0},
      '{CH_AT,    1'b0, ROW_ONE,  EV_START, NO_CODE,       1'b1},
      '{8'h00,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_TAB,   1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{8'hFF,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_NL,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{"G",      1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_NL,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_PLUS,  1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_NL,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{8'h21,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_NL,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},  // counts match
      '{CH_AT,    1'b0, ROW_ONE,  EV_START, NO_CODE,       1'b1},
      '{"x",      1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_NL,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_NL,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{"-",      1'b0, ROW_ONE,  EV_ERROR, ERR_NO_PLUS,   1'b1},
      '{8'h00,    1'b1, ROW_NONE, EV_START, NO_CODE,       1'b0},
      '{CH_GT,    1'b0, ROW_ONE,  EV_START, NO_CODE,       1'b0},
      '{"z",      1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_NL,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},
      '{CH_AT,    1'b0, ROW_PRED, EV_START, NO_CODE,       1'b0},  // closes FASTA, opens next
      '{8'h55,    1'b1, ROW_ONE,  EV_ERROR, ERR_EOF_NAME,  1'b1}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      typed            = '0;
      typed.event_res  = stim_rows[i].ev;
      typed.is_fastq   = stim_rows[i].fq;
      typed.error_code = stim_rows[i].code;
      typed.last       = 1'b1;
      send_item(stim_rows[i].text, stim_rows[i].eos, stim_rows[i].kind, typed);
    end

    // A quality mismatch after a single base, typed as an error code
    text_q = '{};
    send_item(CH_AT, 1'b0, ROW_PRED, '0);
    send_item("q", 1'b0, ROW_PRED, '0);
    send_item(CH_NL, 1'b0, ROW_PRED, '0);
    send_item("A", 1'b0, ROW_PRED, '0);
    send_item(CH_NL, 1'b0, ROW_PRED, '0);
    send_item(CH_PLUS, 1'b0, ROW_PRED, '0);
    send_item(CH_NL, 1'b0, ROW_PRED, '0);
    typed            = '0;
    typed.event_res  = EV_ERROR;
    typed.is_fastq   = 1'b1;
    typed.error_code = ERR_LEN_MISM;
    typed.last       = 1'b1;
    send_item(CH_NL, 1'b0, ROW_ONE, typed);
    send_item(8'h00, 1'b1, ROW_NONE, '0);

    // Random files under several offsets; each phase starts from a drained block
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       v = 8'h00;
        1:       v = 8'hFF;
        2:       v = 8'($urandom_range(1, 254));
        default: v = FQP_QOFS_RESET;
      endcase
      write_quality_offset(v);
      tx_idle = (p == 0) || (p == 3);
      rx_idle = (p == 0) || (p == 2);
      if (p == 2) hold_req = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        build_file();
        while (text_q.size() != 0) begin
          t = text_q.pop_front();
          send_item(t[7:0], t[8], ROW_PRED, '0);
        end
      end
    end

    // Drain and let the block go quiet
    in_valid_i <= 1'b0;
    while (parse_events_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d bytes (%0d live) and %0d result items: %0d records, %0d errors",
             bytes_sent, live_bytes, events_seen, records_closed, errors_seen);
    $display("Quality offsets used: 33 at reset, 0, 255, one random value, 33 rewritten");
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fqp_pkg.sv
rtl/core/fqp_res_fifo.sv
rtl/core/fasta_fastq_record_parser_top.sv
rtl/core/fqp_checker.sv
tb/fasta_fastq_record_parser_top_tb.sv
